FILE: rtl/core/dnsc_pkg.sv
package dnsc_pkg;

    // Limits on label and name length
    localparam int MAX_LABEL_LEN = 63;
    localparam int MAX_NAME_LEN  = 255;

    // Saturating counters must hold the limit plus one
    localparam int LABEL_W = $clog2(MAX_LABEL_LEN + 2);
    localparam int NAME_W  = $clog2(MAX_NAME_LEN + 2);

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Class of the previous accepted byte
    typedef enum logic [1:0] {
        CLS_DOT   = 2'd0,
        CLS_DASH  = 2'd1,
        CLS_ALNUM = 2'd2
    } t_class;

    // Class of an incoming character
    typedef enum logic [2:0] {
        CH_LETTER = 3'd0,
        CH_DIGIT  = 3'd1,
        CH_DASH   = 3'd2,
        CH_DOT    = 3'd3,
        CH_OTHER  = 3'd4
    } t_char;

    // Verdict codes
    typedef enum logic [2:0] {
        RSN_OK     = 3'd0,
        RSN_EMPTY  = 3'd1,
        RSN_LONG   = 3'd2,
        RSN_CHAR   = 3'd3,
        RSN_PLACE  = 3'd4,
        RSN_LABEL  = 3'd5,
        RSN_LETTER = 3'd6
    } t_reason;

    // One item moving from the input register into the checker state
    typedef struct packed {
        logic  vld;
        logic  is_end;
        t_char cls;
    } t_step;

endpackage

FILE: rtl/core/dnsc_classify.sv
module dnsc_classify
    import dnsc_pkg::*;
(
    input  logic [7:0] i_char_byte,
    output t_char      o_cls
);

    always_comb begin
        if ((i_char_byte >= 8'h61 && i_char_byte <= 8'h7A) ||
            (i_char_byte >= 8'h41 && i_char_byte <= 8'h5A)) begin
            o_cls = CH_LETTER;
        end else if (i_char_byte >= 8'h30 && i_char_byte <= 8'h39) begin
            o_cls = CH_DIGIT;
        end else if (i_char_byte == 8'h2D) begin
            o_cls = CH_DASH;
        end else if (i_char_byte == 8'h2E) begin
            o_cls = CH_DOT;
        end else begin
            o_cls = CH_OTHER;
        end
    end

endmodule

FILE: rtl/core/dnsc_state.sv
module dnsc_state
    import dnsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_step   i_step,
    output t_reason o_reason
);

    t_class              r_prev,  n_prev;
    logic [LABEL_W-1:0]  r_label, n_label;
    logic [NAME_W-1:0]   r_name,  n_name;
    logic                r_seen,  n_seen;
    t_reason             r_fail,  n_fail;
    logic                r_start, n_start;

    logic [LABEL_W-1:0]  label_inc;

    // saturate at limit + 1
    assign label_inc = (r_label <= LABEL_W'(MAX_LABEL_LEN)) ? r_label + 1'b1 : r_label;

    always_comb begin
        n_prev  = r_prev;
        n_label = r_label;
        n_name  = r_name;
        n_seen  = r_seen;
        n_fail  = r_fail;
        n_start = r_start;
        if (i_step.vld && i_step.is_end) begin
            // verdict taken, back to the reset state
            n_prev  = CLS_DOT;
            n_label = '0;
            n_name  = '0;
            n_seen  = 1'b0;
            n_fail  = RSN_OK;
            n_start = 1'b1;
        end else if (i_step.vld) begin
            n_start = 1'b0;
            if (r_name <= NAME_W'(MAX_NAME_LEN)) begin
                n_name = r_name + 1'b1;
            end
            // leading dot is skipped; after a failure only the length moves
            if (!(r_start && i_step.cls == CH_DOT) && r_fail == RSN_OK) begin
                case (i_step.cls)
                    CH_LETTER: begin
                        n_seen  = 1'b1;
                        n_label = label_inc;
                        n_prev  = CLS_ALNUM;
                    end
                    CH_DIGIT: begin
                        n_label = label_inc;
                        n_prev  = CLS_ALNUM;
                    end
                    CH_DASH: begin
                        if (r_prev == CLS_DOT) begin
                            n_fail = RSN_PLACE;
                        end else begin
                            n_label = label_inc;
                            n_prev  = CLS_DASH;
                        end
                    end
                    CH_DOT: begin
                        if (r_prev == CLS_DOT || r_prev == CLS_DASH) begin
                            n_fail = RSN_PLACE;
                        end else if (r_label > LABEL_W'(MAX_LABEL_LEN) ||
                                     r_label == '0) begin
                            n_fail = RSN_LABEL;
                        end else begin
                            n_label = '0;
                            n_prev  = CLS_DOT;
                        end
                    end
                    default: begin
                        n_fail = RSN_CHAR;
                    end
                endcase
            end
        end
    end

    // verdict in priority order
    always_comb begin
        if (r_name == '0) begin
            o_reason = RSN_EMPTY;
        end else if (r_name > NAME_W'(MAX_NAME_LEN)) begin
            o_reason = RSN_LONG;
        end else if (r_fail != RSN_OK) begin
            o_reason = r_fail;
        end else if (r_prev == CLS_DASH) begin
            o_reason = RSN_PLACE;
        end else if (r_label > LABEL_W'(MAX_LABEL_LEN)) begin
            o_reason = RSN_LABEL;
        end else if (!r_seen) begin
            o_reason = RSN_LETTER;
        end else begin
            o_reason = RSN_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= CLS_DOT;
            r_label <= '0;
            r_name  <= '0;
            r_seen  <= 1'b0;
            r_fail  <= RSN_OK;
            r_start <= 1'b1;
        end else begin
            r_prev  <= n_prev;
            r_label <= n_label;
            r_name  <= n_name;
            r_seen  <= n_seen;
            r_fail  <= n_fail;
            r_start <= n_start;
        end
    end

endmodule

FILE: rtl/core/domain_name_syntax_checker_unit.sv
// Domain name syntax checker.
// Input channel (i_valid / o_stall): one item per handshake. An item with
// i_kind = 0 carries one character of the name in i_char_byte; an item with
// i_kind = 1 ends the name and asks for the verdict. Byte items give no
// result. Output channel (o_valid / i_stall): one item per end item, with
// o_valid_res = 1 for a valid name and o_reason giving the first failing
// check (0 ok, 1 empty, 2 too long, 3 bad character, 4 bad dot or dash
// placement, 5 bad label length, 6 no letter).
// Throughput: one item per cycle, sustained while no end item waits on
// i_stall, set by the single pass of classify and update logic between the
// input register and the state. An end item accepted into the input register
// leaves it with its verdict written into the output register.
// Stall: while a verdict waits on i_stall, byte items keep flowing into the
// checker state; only an end item waits in the input register, and then
// o_stall holds the input side. After each verdict the state returns to its
// reset values for the next name.
// Reset: synchronous, active low; both registers empty, checker state at
// start of a name. No clearing pass is needed.
module domain_name_syntax_checker_unit
    import dnsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_char_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_valid_res,
    output logic [2:0] o_reason
);

    // input register
    logic       r_in_vld;
    logic       r_in_kind;
    logic [7:0] r_in_char;

    // result register
    logic       r_out_vld;
    logic       r_out_res;
    t_reason    r_out_reason;

    logic       in_take;
    logic       out_take;
    logic       advance;
    t_char      cls;
    t_step      step;
    t_reason    verdict;

    // byte items always move on; an end item needs room in the result register
    assign out_take = r_out_vld && !i_stall;
    assign advance  = r_in_vld && (r_in_kind == KIND_BYTE || !r_out_vld || !i_stall);
    assign o_stall  = r_in_vld && !advance;
    assign in_take  = i_valid && !o_stall;

    dnsc_classify u_classify (
        .i_char_byte (r_in_char),
        .o_cls       (cls)
    );

    assign step.vld    = advance;
    assign step.is_end = (r_in_kind == KIND_END);
    assign step.cls    = cls;

    dnsc_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_reason (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind <= i_kind;
            r_in_char <= i_char_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && r_in_kind == KIND_END) begin
            r_out_vld <= 1'b1;
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_kind == KIND_END) begin
            r_out_res    <= (verdict == RSN_OK);
            r_out_reason <= verdict;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_valid_res = r_out_res;
    assign o_reason    = r_out_reason;

endmodule

FILE: rtl/core/dnsc_checker.sv
module dnsc_checker
    import dnsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_kind,
    input logic [7:0] i_char_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_valid_res,
    input logic [2:0] o_reason
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_valid_res) && $stable(o_reason))
        else $error("result changed under stall");

    // stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_kind) && $stable(i_char_byte))
        else $error("input item changed under stall");

    // valid flag agrees with reason code
    a_res_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_valid_res == (o_reason == RSN_OK)))
        else $error("valid_res disagrees with reason");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // input side never blocked while the output side is empty
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty result register");

endmodule

bind domain_name_syntax_checker_unit dnsc_checker u_dnsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_kind      (i_kind),
    .i_char_byte (i_char_byte),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_valid_res (o_valid_res),
    .o_reason    (o_reason)
);

FILE: tb/dns_verdict_checker.sv
module dns_verdict_checker
    import dnsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_char_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_valid_res,
    input  logic [2:0] i_reason,
    output int         o_fails,
    output int         o_due,
    output int         o_verdicts,
    output logic [7:0] o_reason_mask
);

    typedef struct packed {
        logic    ok;
        t_reason why;
    } t_verdict;

    // Shadow of the name being scanned
    t_class             prev_cls    = CLS_DOT;
    logic [LABEL_W-1:0] label_cnt   = '0;
    logic [NAME_W-1:0]  name_cnt    = '0;
    logic               letter_seen = 1'b0;
    t_reason            first_bad   = RSN_OK;
    logic               name_start  = 1'b1;

    t_verdict verdict_q[$];
    int       fail_cnt = 0;
    int       verdict_cnt = 0;

    function void clear_name();
        prev_cls    = CLS_DOT;
        label_cnt   = '0;
        name_cnt    = '0;
        letter_seen = 1'b0;
        first_bad   = RSN_OK;
        name_start  = 1'b1;
    endfunction

    function t_char sort_char(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CH_LETTER;
        if (c >= "0" && c <= "9") return CH_DIGIT;
        if (c == "-") return CH_DASH;
        if (c == ".") return CH_DOT;
        return CH_OTHER;
    endfunction

    function void bump_label();
        if (label_cnt <= MAX_LABEL_LEN) label_cnt = label_cnt + 1'b1;
    endfunction

    function void take_char(input logic [7:0] c);
        logic  starting;
        t_char cls;
        starting   = name_start;
        name_start = 1'b0;
        cls        = sort_char(c);
        // name length keeps counting after a failure, up to limit + 1
        if (name_cnt <= MAX_NAME_LEN) name_cnt = name_cnt + 1'b1;
        if (starting && cls == CH_DOT) return;
        if (first_bad != RSN_OK) return;
        case (cls)
            CH_LETTER: begin
                letter_seen = 1'b1;
                bump_label();
                prev_cls = CLS_ALNUM;
            end
            CH_DIGIT: begin
                bump_label();
                prev_cls = CLS_ALNUM;
            end
            CH_DASH: begin
                if (prev_cls == CLS_DOT) begin
                    first_bad = RSN_PLACE;
                end else begin
                    bump_label();
                    prev_cls = CLS_DASH;
                end
            end
            CH_DOT: begin
                if (prev_cls != CLS_ALNUM) begin
                    first_bad = RSN_PLACE;
                end else if (label_cnt > MAX_LABEL_LEN || label_cnt == 0) begin
                    first_bad = RSN_LABEL;
                end else begin
                    label_cnt = '0;
                    prev_cls  = CLS_DOT;
                end
            end
            default: first_bad = RSN_CHAR;
        endcase
    endfunction

    function t_reason judge_name();
        if (name_cnt == 0) return RSN_EMPTY;
        if (name_cnt > MAX_NAME_LEN) return RSN_LONG;
        if (first_bad != RSN_OK) return first_bad;
        if (prev_cls == CLS_DASH) return RSN_PLACE;
        if (label_cnt > MAX_LABEL_LEN) return RSN_LABEL;
        if (!letter_seen) return RSN_LETTER;
        return RSN_OK;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            clear_name();
            verdict_q.delete();
            o_due         <= 0;
            o_reason_mask <= '0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_END) begin
                    want.why = judge_name();
                    want.ok  = (want.why == RSN_OK);
                    verdict_q.push_back(want);
                    o_reason_mask <= o_reason_mask | (8'd1 << want.why);
                    clear_name();
                end else begin
                    take_char(i_char_byte);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict item with none pending: valid_res=%0d reason=%0d",
                           i_valid_res, i_reason);
                    fail_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    verdict_cnt++;
                    if (i_valid_res !== want.ok) begin
                        $error("valid_res: expected %0d, actual %0d", want.ok, i_valid_res);
                        fail_cnt++;
                    end
                    if (i_reason !== want.why) begin
                        $error("reason: expected %0d, actual %0d", want.why, i_reason);
                        fail_cnt++;
                    end
                end
            end
            o_due <= verdict_q.size();
        end
        o_fails    <= fail_cnt;
        o_verdicts <= verdict_cnt;
    end

endmodule

FILE: tb/tb_top.sv
// Top of the bench for the domain name syntax checker.
// Feeds names one byte item at a time, each closed by an end item, and
// leaves all prediction and comparison to dns_verdict_checker. Stimulus:
// a short directed list of corner names, a long receiver hold while short
// names stream in, then random names (mostly well formed, the rest mutated
// or pure noise) with a handful of very long labels and names mixed in.
// Both sides idle at random, with stretches of back-to-back traffic.
module tb_top;
    import dnsc_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int ITEM_TARGET = 850;     // input items to send, all kinds
    localparam int LONG_HOLD   = 200;     // receiver hold-off, in cycles
    localparam int TAIL_CYCLES = 20;      // quiet time after the last verdict
    localparam int RUN_LIMIT   = 3000000; // hard stop, time units

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_kind   = KIND_BYTE;
    logic [7:0] in_char   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       out_valid_res;
    logic [2:0] out_reason;

    int         fails;
    int         due;
    int         verdicts;
    logic [7:0] reason_mask;

    int names_sent    = 0;
    int items_sent    = 0;
    int hold_requests = 0;  // bumped by stimulus, served by the receiver
    bit tx_steady     = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    domain_name_syntax_checker_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_kind      (in_kind),
        .i_char_byte (in_char),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_valid_res (out_valid_res),
        .o_reason    (out_reason)
    );

    dns_verdict_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_kind        (in_kind),
        .i_char_byte   (in_char),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_valid_res   (out_valid_res),
        .i_reason      (out_reason),
        .o_fails       (fails),
        .o_due         (due),
        .o_verdicts    (verdicts),
        .o_reason_mask (reason_mask)
    );

    // Receiver: after each accepted verdict, hold off for a random wait (none while
    // rx_steady); on request hold off for LONG_HOLD so end items back up into the block.
    int rx_wait_left  = 0;
    int hold_left     = 0;
    int holds_served  = 0;
    bit rx_steady     = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (out_valid && !out_stall) begin
                if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
                rx_wait_left = rx_steady ? 0 : $urandom_range(0, 15);
            end else if (rx_wait_left > 0) begin
                rx_wait_left--;
            end
            if (hold_left > 0) hold_left--;
            out_stall <= (hold_left > 0) || (rx_wait_left > 0);
        end
    end

    // One item: idle for a random gap (none while tx_steady), present it, wait for the handshake.
    // Returns in the time step of the accepting edge with valid still high.
    task automatic offer(input logic kind, input logic [7:0] c);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_char  <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_name(input byte_q_t q);
        foreach (q[i]) offer(KIND_BYTE, q[i]);
        // char_byte is don't-care on an end item; keep it random
        offer(KIND_END, 8'($urandom_range(0, 255)));
        names_sent++;
    endtask

    // Sender goes quiet until every pending verdict has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due != 0) @(posedge clk);
    endtask

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 2) == 0) return "0" + 8'($urandom_range(0, 9));
        return rand_letter();
    endfunction

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 5))
            0: return rand_letter();
            1: return "0" + 8'($urandom_range(0, 9));
            2: return "-";
            3: return ".";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed shape: optional leading dot, 1..4 labels, dashes only
    // inside a label, optional trailing dot. Short all-digit names still
    // show up and miss the letter rule.
    function automatic byte_q_t good_name();
        byte_q_t q;
        int      labels;
        int      len;
        if ($urandom_range(0, 7) == 0) q.push_back(".");
        labels = $urandom_range(1, 4);
        for (int l = 0; l < labels; l++) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                if (k > 0 && k < len - 1 && $urandom_range(0, 4) == 0) q.push_back("-");
                else q.push_back(rand_alnum());
            end
            if (l < labels - 1) q.push_back(".");
        end
        if ($urandom_range(0, 7) == 0) q.push_back(".");
        return q;
    endfunction

    function automatic byte_q_t random_name();
        byte_q_t q;
        int      n;
        case ($urandom_range(0, 9))
            6, 7: begin
                // good shape with one or two stray bytes dropped in
                q = good_name();
                n = $urandom_range(1, 2);
                repeat (n) q.insert($urandom_range(0, q.size()), any_byte());
            end
            8: begin
                n = $urandom_range(0, 10);
                repeat (n) q.push_back(any_byte());
            end
            9: begin
                // dot and dash placement soup
                n = $urandom_range(1, 8);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: q.push_back(rand_letter());
                        1: q.push_back("7");
                        2: q.push_back("-");
                        default: q.push_back(".");
                    endcase
                end
            end
            default: q = good_name();
        endcase
        return q;
    endfunction

    // Letters with a dot after every label_max of them
    function automatic byte_q_t span_name(input int total, input int label_max);
        byte_q_t q;
        for (int i = 0; i < total; i++) begin
            if (i % (label_max + 1) == label_max) q.push_back(".");
            else q.push_back(rand_letter());
        end
        return q;
    endfunction

    function automatic byte_q_t big_name(input int idx);
        case (idx)
            0: return span_name(255, 63);   // longest legal name, 63-byte labels
            1: return span_name(66, 65);    // label counter saturates, dot closes
            2: return span_name(64, 64);    // label one over, at the end
            default: return span_name(257, 63);  // name counter saturates
        endcase
    endfunction

    initial begin : stimulus
        byte_q_t q;
        int      big_idx;
        int      name_idx;
        big_idx  = 0;
        name_idx = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // corner names: empty, single letter, lone dot, leading dot,
        // dash first, trailing dot, trailing dash, digits only, NUL, 0xFF
        send_name(text_bytes(""));
        send_name(text_bytes("a"));
        send_name(text_bytes("."));
        send_name(text_bytes(".a"));
        send_name(text_bytes("-a"));
        send_name(text_bytes("a."));
        send_name(text_bytes("a-"));
        send_name(text_bytes("1"));
        q = '{8'h00};
        send_name(q);
        q = '{8'hFF};
        send_name(q);
        drain();

        // long receiver hold while short names keep streaming in
        hold_requests <= hold_requests + 1;
        tx_steady = 1'b1;
        send_name(text_bytes("ab"));
        send_name(text_bytes("c-d"));
        send_name(text_bytes("e.f"));
        send_name(text_bytes("9"));
        tx_steady = 1'b0;
        drain();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
            if (name_idx % 3 == 1 && big_idx < 4) begin
                send_name(big_name(big_idx));
                big_idx++;
            end else begin
                q = random_name();
                send_name(q);
            end
            if (name_idx == 6) drain();
            name_idx++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d names in %0d items; %0d verdicts compared",
                 names_sent, items_sent, verdicts);
        $display("reason codes hit (bit n = code n): %b", reason_mask);
        if (fails == 0 && due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $error("run did not finish in time, %0d verdicts still pending", due);
        $display("status: fail");
        $finish;
    end

endmodule
